// ----- src/mt64_pkg.sv -----
// shared types and constants of the 64-bit twister generator
package mt64_pkg;

    localparam int unsigned TABLE_WORDS   = 312;
    localparam int unsigned MIDDLE_OFFSET = 156;
    localparam int unsigned IDX_W         = 9;
    localparam int unsigned DATA_W        = 64;

    localparam logic [63:0] SEED_RESET  = 64'd42;
    localparam logic [63:0] SEED_MULT   = 64'd6364136223846793005;
    localparam logic [63:0] TWIST_XOR   = 64'hB5026F5AA96619E9;
    localparam logic [63:0] HIGH_MASK   = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LOW_MASK    = 64'h000000007FFFFFFF;
    localparam logic [63:0] TEMPER_A    = 64'h5555555555555555;
    localparam logic [63:0] TEMPER_B    = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TEMPER_C    = 64'hFFF7EEE000000000;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_DRAW   = 2'd1;
    localparam logic [1:0] OP_ROLL   = 2'd2;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_SEED0,
        DP_MIX,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_SEEDW,
        DP_RG_INIT,
        DP_RG_HI,
        DP_RG_NXT,
        DP_RG_MID,
        DP_DRAW_ADDR,
        DP_DRAW_DATA,
        DP_DIV_STEP,
        DP_DIV_Q,
        DP_STEP_SAVE,
        DP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_WORD,
        RES_QUOT
    } res_sel_t;

    typedef struct packed {
        dp_op_t   op;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic idx_full;
        logic pos_last;
        logic n_zero;
        logic div_busy;
        logic quot_ge_n;
        logic out_free;
    } status_t;

endpackage

// ----- src/mt64_ram.sv -----
// generic single-port-write ram with registered read
module mt64_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 312
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/mt64_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
module mt64_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [63:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb begin
        shifted   = {rem_reg, quot_reg[63]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = shifted[63:0];
        quot_next = {quot_reg[62:0], 1'b0};
        if (shifted >= {1'b0, dvs_reg}) begin
            rem_next  = diff[63:0];
            quot_next = {quot_reg[62:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 7'd64;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quot_reg;
endmodule

// ----- src/mt64_datapath.sv -----
// datapath: state table, seeding multiplier, twist, tempering, divider, output register
module mt64_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  mt64_pkg::cmd_t   cmd,
    output mt64_pkg::status_t status,
    input  logic [63:0]      s_range_limit,
    input  logic             cfg_valid,
    input  logic [63:0]      cfg_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [63:0]      m_value
);
    import mt64_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [63:0] seed_reg;
    logic [63:0] prev_reg;
    logic [63:0] mix_reg;
    logic [63:0] prod_reg;
    logic [63:0] hi_reg;
    logic [63:0] y_reg;
    logic [63:0] n_reg;
    logic [63:0] step_reg;
    logic [63:0] word_reg;
    logic [63:0] out_value_reg;
    logic        out_valid_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [63:0]      ram_rdata;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] seed_word;
    logic [63:0] twist_word;
    logic [63:0] y_now;

    logic        div_start;
    logic [63:0] div_dividend, div_divisor, div_quot;
    logic        div_busy;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] v);
        logic [IDX_W:0] r;
        r = (v >= (IDX_W+1)'(TABLE_WORDS)) ? v - (IDX_W+1)'(TABLE_WORDS) : v;
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] x;
        x = w ^ ((w >> 29) & TEMPER_A);
        x = x ^ ((x << 17) & TEMPER_B);
        x = x ^ ((x << 37) & TEMPER_C);
        x = x ^ (x >> 43);
        return x;
    endfunction

    mt64_ram #(.WIDTH(64), .DEPTH(TABLE_WORDS)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mt64_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // shared 32x32 multiplier for the low 64 bits of the seed product
    always_comb begin
        mul_a = mix_reg[31:0];
        mul_b = SEED_MULT[31:0];
        case (cmd.op)
            DP_MUL1: mul_a = mix_reg[63:32];
            DP_MUL2: mul_b = SEED_MULT[63:32];
            default: ;
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    assign seed_word  = prod_reg + {{(64-IDX_W){1'b0}}, pos_reg};
    assign y_now      = (hi_reg & HIGH_MASK) | (ram_rdata & LOW_MASK);
    assign twist_word = ram_rdata ^ (y_reg >> 1) ^ (y_reg[0] ? TWIST_XOR : 64'd0);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = twist_word;
        ram_raddr = '0;
        case (cmd.op)
            DP_SEED0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = seed_reg;
            end
            DP_SEEDW: begin
                ram_we    = 1'b1;
                ram_wdata = seed_word;
            end
            DP_RG_HI:     ram_raddr = wrap({1'b0, pos_reg} + (IDX_W+1)'(1));
            DP_RG_NXT:    ram_raddr = wrap({1'b0, pos_reg} + (IDX_W+1)'(MIDDLE_OFFSET));
            DP_RG_MID: begin
                ram_we    = 1'b1;
                ram_raddr = wrap({1'b0, pos_reg} + (IDX_W+1)'(2));
            end
            DP_DRAW_ADDR: ram_raddr = idx_reg;
            default: ;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = word_reg;
        div_divisor  = step_reg;
        case (cmd.op)
            DP_DIV_STEP: begin
                div_start    = 1'b1;
                div_dividend = '1;
                div_divisor  = n_reg;
            end
            DP_DIV_Q: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= SEED_RESET;
            idx_reg       <= IDX_W'(TABLE_WORDS);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                seed_reg <= cfg_data;
            end
            if (cmd.op == DP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                // table is regenerated lazily on the next draw
                DP_SEEDW:     if (status.pos_last) idx_reg <= IDX_W'(TABLE_WORDS);
                DP_RG_MID:    if (status.pos_last) idx_reg <= '0;
                DP_DRAW_ADDR: idx_reg <= idx_reg + IDX_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_ACCEPT:    n_reg <= s_range_limit;
            DP_SEED0: begin
                prev_reg <= seed_reg;
                pos_reg  <= IDX_W'(1);
            end
            DP_MIX:       mix_reg <= prev_reg ^ (prev_reg >> 62);
            DP_MUL0:      prod_reg <= mul_p;
            DP_MUL1, DP_MUL2: prod_reg[63:32] <= prod_reg[63:32] + mul_p[31:0];
            DP_SEEDW: begin
                prev_reg <= seed_word;
                pos_reg  <= pos_reg + IDX_W'(1);
            end
            DP_RG_INIT:   pos_reg <= '0;
            DP_RG_HI:     hi_reg <= ram_rdata;
            DP_RG_NXT: begin
                y_reg  <= y_now;
                hi_reg <= ram_rdata;
            end
            DP_RG_MID:    pos_reg <= pos_reg + IDX_W'(1);
            DP_DRAW_DATA: word_reg <= temper(ram_rdata);
            DP_STEP_SAVE: step_reg <= div_quot;
            DP_OUT: begin
                case (cmd.res_sel)
                    RES_WORD: out_value_reg <= word_reg;
                    RES_QUOT: out_value_reg <= div_quot;
                    default:  out_value_reg <= '0;
                endcase
            end
            default: ;
        endcase
    end

    assign status.idx_full  = (idx_reg == IDX_W'(TABLE_WORDS));
    assign status.pos_last  = (pos_reg == IDX_W'(TABLE_WORDS - 1));
    assign status.n_zero    = (n_reg == '0);
    assign status.div_busy  = div_busy;
    assign status.quot_ge_n = (div_quot >= n_reg);
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
endmodule

// ----- src/mt64_ctrl.sv -----
// controller state machine sequencing seeding, regeneration, draws and rolls
module mt64_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  mt64_pkg::status_t status,
    output mt64_pkg::cmd_t    cmd
);
    import mt64_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SEED0, S_MIX, S_MUL0, S_MUL1, S_MUL2, S_SEEDW,
        S_RG_INIT, S_RG_HI, S_RG_NXT, S_RG_MID,
        S_DRAW, S_DRAW_DATA, S_ROLL_CHK, S_STEP_START, S_STEP_WAIT,
        S_Q_START, S_Q_WAIT, S_DONE
    } state_t;

    state_t   state_reg;
    logic     reply_reg;
    logic     roll_reg;
    res_sel_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SEED0;
            reply_reg <= 1'b0;
            roll_reg  <= 1'b0;
            res_reg   <= RES_ZERO;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        res_reg <= RES_ZERO;
                        case (s_opcode)
                            OP_RESEED: begin
                                reply_reg <= 1'b1;
                                state_reg <= S_SEED0;
                            end
                            OP_DRAW: begin
                                roll_reg  <= 1'b0;
                                state_reg <= S_DRAW;
                            end
                            OP_ROLL: begin
                                roll_reg  <= 1'b1;
                                state_reg <= S_ROLL_CHK;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SEED0:  state_reg <= S_MIX;
                S_MIX:    state_reg <= S_MUL0;
                S_MUL0:   state_reg <= S_MUL1;
                S_MUL1:   state_reg <= S_MUL2;
                S_MUL2:   state_reg <= S_SEEDW;
                S_SEEDW: begin
                    if (!status.pos_last) begin
                        state_reg <= S_MIX;
                    end else if (reply_reg) begin
                        res_reg   <= RES_ZERO;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RG_INIT: state_reg <= S_RG_HI;
                S_RG_HI:   state_reg <= S_RG_NXT;
                S_RG_NXT:  state_reg <= S_RG_MID;
                S_RG_MID:  state_reg <= status.pos_last ? S_DRAW : S_RG_NXT;
                S_DRAW:    state_reg <= status.idx_full ? S_RG_INIT : S_DRAW_DATA;
                S_DRAW_DATA: begin
                    if (roll_reg) begin
                        state_reg <= S_Q_START;
                    end else begin
                        res_reg   <= RES_WORD;
                        state_reg <= S_DONE;
                    end
                end
                S_ROLL_CHK: begin
                    if (status.n_zero) begin
                        res_reg   <= RES_ZERO;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_STEP_START;
                    end
                end
                S_STEP_START: state_reg <= S_STEP_WAIT;
                S_STEP_WAIT:  if (!status.div_busy) state_reg <= S_DRAW;
                S_Q_START:    state_reg <= S_Q_WAIT;
                S_Q_WAIT: begin
                    if (!status.div_busy) begin
                        // quotients of n or more are rejected and redrawn
                        if (status.quot_ge_n) begin
                            state_reg <= S_DRAW;
                        end else begin
                            res_reg   <= RES_QUOT;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: if (status.out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.op      = DP_NOP;
        cmd.res_sel = res_reg;
        case (state_reg)
            S_IDLE:       if (s_valid) cmd.op = DP_ACCEPT;
            S_SEED0:      cmd.op = DP_SEED0;
            S_MIX:        cmd.op = DP_MIX;
            S_MUL0:       cmd.op = DP_MUL0;
            S_MUL1:       cmd.op = DP_MUL1;
            S_MUL2:       cmd.op = DP_MUL2;
            S_SEEDW:      cmd.op = DP_SEEDW;
            S_RG_INIT:    cmd.op = DP_RG_INIT;
            S_RG_HI:      cmd.op = DP_RG_HI;
            S_RG_NXT:     cmd.op = DP_RG_NXT;
            S_RG_MID:     cmd.op = DP_RG_MID;
            S_DRAW:       if (!status.idx_full) cmd.op = DP_DRAW_ADDR;
            S_DRAW_DATA:  cmd.op = DP_DRAW_DATA;
            S_STEP_START: cmd.op = DP_DIV_STEP;
            S_STEP_WAIT:  if (!status.div_busy) cmd.op = DP_STEP_SAVE;
            S_Q_START:    cmd.op = DP_DIV_Q;
            S_DONE:       if (status.out_free) cmd.op = DP_OUT;
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
endmodule

// ----- src/mt64_random_generator.sv -----
// MT19937-64 generator: one request at a time. A raw draw reads the 312-word state table through
// its single read port, tempers the word and registers the result, and the next request is taken
// once the output register is free to take that result; the first draw after a reseed and every
// 312th draw after it first regenerate the table in place. A roll adds a divide for the bound step
// and, per draw, a quotient divide on the 1-bit-per-cycle divider, repeated on rejection. Reseed
// (and the start after reset, before the first request is taken) writes the table through a
// shared 32x32 multiplier, one word per pass through the mix, multiply and write steps. The seed
// register may be written at any time through the cfg channel and takes effect at the next reseed.
module mt64_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_range_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import mt64_pkg::*;

    cmd_t    cmd;
    status_t status;

    mt64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .status   (status),
        .cmd      (cmd)
    );

    mt64_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_range_limit (s_range_limit),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value)
    );

    assign cfg_ready = 1'b1;
endmodule

// ----- src/mt64_checker.sv -----
// port-level checks of the generator and their binding
module mt64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_value
);
    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // a new result appears only after the block was busy
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work");

    // nothing is taken and no result is valid right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity right after reset");
endmodule

bind mt64_random_generator mt64_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value)
);

// ----- test/mt64_random_generator_tb.sv -----
// self-checking testbench of the 64-bit twister random generator
`timescale 1ns / 100ps

module mt64_random_generator_tb;
    import mt64_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [63:0] s_range_limit;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 40000;

    // own copy of the generator state
    logic [63:0] twist_words [TABLE_WORDS];
    int unsigned twist_pos;
    logic [63:0] seed_word;

    logic [63:0] expected_values [$];
    int unsigned mismatch_count;
    int unsigned value_count;
    int unsigned request_count;
    int unsigned idle_cycles;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    bit          receiver_hold;

    mt64_random_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_range_limit (s_range_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void seed_table(logic [63:0] s);
        twist_words[0] = s;
        for (int i = 1; i < TABLE_WORDS; i++) begin
            twist_words[i] = SEED_MULT * (twist_words[i-1] ^ (twist_words[i-1] >> 62))
                             + 64'(i);
        end
    endfunction

    function automatic void twist_table();
        logic [63:0] y;
        logic [63:0] t;
        for (int i = 0; i < TABLE_WORDS; i++) begin
            y = (twist_words[i] & HIGH_MASK) | (twist_words[(i + 1) % TABLE_WORDS] & LOW_MASK);
            t = twist_words[(i + MIDDLE_OFFSET) % TABLE_WORDS] ^ (y >> 1);
            if (y[0]) t ^= TWIST_XOR;
            twist_words[i] = t;
        end
        twist_pos = 0;
    endfunction

    function automatic logic [63:0] tempered_word();
        logic [63:0] x;
        if (twist_pos >= TABLE_WORDS) twist_table();
        x = twist_words[twist_pos];
        twist_pos++;
        x ^= (x >> 29) & TEMPER_A;
        x ^= (x << 17) & TEMPER_B;
        x ^= (x << 37) & TEMPER_C;
        x ^= (x >> 43);
        return x;
    endfunction

    function automatic logic [63:0] predict_value(logic [1:0] op, logic [63:0] n);
        logic [63:0] step;
        logic [63:0] q;
        case (op)
            OP_RESEED: begin
                seed_table(seed_word);
                twist_table();
                return 64'd0;
            end
            OP_DRAW: return tempered_word();
            OP_ROLL: begin
                if (n == 64'd0) return 64'd0;
                step = 64'hFFFF_FFFF_FFFF_FFFF / n;
                do q = tempered_word() / step; while (q >= n);
                return q;
            end
            default: return 64'd0;
        endcase
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            value_count++;
            if (expected_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result value=%h", m_value);
            end else begin
                logic [63:0] want;
                want = expected_values.pop_front();
                if (m_value !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("value mismatch: expected %h got %h", want, m_value);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_values.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] op, logic [63:0] n);
        while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_range_limit <= n;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_values.push_back(predict_value(op, n));
        request_count++;
        s_valid       <= 1'b0;
        s_opcode      <= 2'($urandom());
        s_range_limit <= {$urandom(), $urandom()};
        // the block is busy after a request anyway
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_seed(logic [63:0] s);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        seed_word = s;
    endtask

    function automatic logic [63:0] random_bound();
        case ($urandom_range(4))
            0: return 64'($urandom_range(1, 16));
            1: return 64'($urandom());
            2: return {$urandom(), $urandom()};
            3: return 64'h8000_0000_0000_0000 + 64'($urandom_range(3));
            default: return {$urandom(), $urandom()} >> $urandom_range(63);
        endcase
    endfunction

    task automatic random_request();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 2)
            send_request(OP_RESEED, {$urandom(), $urandom()});
        else if (pick < 55)
            send_request(OP_DRAW, {$urandom(), $urandom()});
        else if (pick < 95)
            send_request(OP_ROLL, random_bound());
        else if (pick < 97)
            send_request(OP_ROLL, 64'd0);
        else
            send_request(OP_NONE, {$urandom(), $urandom()});
    endtask

    task automatic test_directed();
        send_request(OP_DRAW, 64'd0);
        send_request(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_ROLL, 64'd1);
        send_request(OP_ROLL, 64'd2);
        send_request(OP_ROLL, 64'd6);
        send_request(OP_ROLL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_ROLL, 64'h8000_0000_0000_0000);
        send_request(OP_ROLL, 64'h8000_0000_0000_0001);
        send_request(OP_ROLL, 64'd0);
        send_request(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_RESEED, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_DRAW, 64'h5555_5555_5555_5555);
        write_seed(64'd1);
        send_request(OP_RESEED, 64'd0);
        send_request(OP_DRAW, 64'd0);
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_RESEED, 64'd0);
        send_request(OP_DRAW, 64'd0);
        write_seed(64'd0);
        send_request(OP_RESEED, 64'd0);
        send_request(OP_DRAW, 64'd0);
        drain_results();
    endtask

    // walks past the table end so the in-place twist is exercised
    task automatic test_table_wrap();
        for (int i = 0; i < 340; i++) send_request(OP_DRAW, 64'd0);
        drain_results();
    endtask

    task automatic test_random_phase(int unsigned count, int unsigned s_pct, int unsigned r_pct);
        sender_idle_pct    = s_pct;
        receiver_stall_pct = r_pct;
        for (int i = 0; i < count; i++) random_request();
        drain_results();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                receiver_hold = 1'b1;
                repeat (400) @(posedge aclk);
                receiver_hold = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_request(OP_DRAW, 64'd0);
        join
        drain_results();
    endtask

    task automatic test_seed_sweep();
        write_seed({$urandom(), $urandom()});
        test_random_phase(100, 0, 0);
        write_seed(64'd42);
        send_request(OP_RESEED, 64'd0);
        test_random_phase(100, 17, 17);
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_opcode           = OP_DRAW;
        s_range_limit      = 64'd0;
        cfg_valid          = 1'b0;
        cfg_data           = 64'd0;
        receiver_hold      = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        value_count        = 0;
        request_count      = 0;
        seed_word          = SEED_RESET;
        seed_table(seed_word);
        twist_table();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_table_wrap();
        test_backpressure();
        test_random_phase(250, 0, 0);
        test_random_phase(250, 62, 0);
        test_random_phase(250, 0, 62);
        test_random_phase(250, 17, 17);
        test_seed_sweep();
        repeat (50) @(posedge aclk);

        $display("covered %0d requests and %0d results: draws, rolls, reseeds, table wrap,",
                 request_count, value_count);
        $display("seed extremes, idle and stall phases, and a long output hold-off");
        if (mismatch_count == 0 && expected_values.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_values.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
